@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the standard clock and reset names
`define ASSERT_STD(label, prop, msg) `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

@@ rtl/mlr_pkg.sv @@
package mlr_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_W  = 13;
    localparam int SCREEN_W = 12;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int INC_W    = COORD_W + 3;
    localparam int DIAG_W   = COORD_W + 4;
    localparam int DEC_W    = COORD_W + 5;
    localparam int CMP_W    = (COORD_W - 1 > SCREEN_W) ? COORD_W - 1 : SCREEN_W;

    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic        [COORD_W-1:0]  t_mag;
    typedef logic        [INC_W-1:0]    t_inc;
    typedef logic signed [DIAG_W-1:0]   t_diag;
    typedef logic signed [DEC_W-1:0]    t_dec;
    typedef logic        [SCREEN_W-1:0] t_screen;
    typedef logic        [CMP_W-1:0]    t_cmp;

    // request operation codes
    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

    // prepared line set-up, ready to load into the stepping state
    typedef struct packed {
        t_coord maj0;
        t_coord min0;
        t_coord maj1;
        t_inc   straight;
        t_diag  diag;
        t_dec   dec;
        logic   steep;
        logic   goes_down;
        logic   single;
    } t_setup;

endpackage

@@ rtl/mlr_setup.sv @@
module mlr_setup (
    input  mlr_pkg::t_coord i_x0,
    input  mlr_pkg::t_coord i_y0,
    input  mlr_pkg::t_coord i_x1,
    input  mlr_pkg::t_coord i_y1,
    output mlr_pkg::t_setup o_setup
);
    import mlr_pkg::*;

    typedef logic signed [DIFF_W-1:0] t_diff;

    t_diff dx;
    t_diff dy;
    t_mag  adx;
    t_mag  ady;
    logic  steep;
    logic  swap;
    t_diff dmaj_s;
    t_diff dmin_s;
    t_mag  dmaj;
    t_mag  dmin;

    // endpoint deltas and their magnitudes
    assign dx  = t_diff'(i_x1) - t_diff'(i_x0);
    assign dy  = t_diff'(i_y1) - t_diff'(i_y0);
    assign adx = dx[DIFF_W-1] ? t_mag'(-dx) : t_mag'(dx);
    assign ady = dy[DIFF_W-1] ? t_mag'(-dy) : t_mag'(dy);

    // major axis choice and endpoint ordering
    assign steep  = ady >= adx;
    assign dmaj_s = steep ? dy : dx;
    assign dmin_s = steep ? dx : dy;
    assign swap   = dmaj_s[DIFF_W-1];
    assign dmaj   = steep ? ady : adx;
    assign dmin   = steep ? adx : ady;

    // start point, increments and initial decision
    always_comb begin
        o_setup.maj0      = swap ? (steep ? i_y1 : i_x1) : (steep ? i_y0 : i_x0);
        o_setup.min0      = swap ? (steep ? i_x1 : i_y1) : (steep ? i_x0 : i_y0);
        o_setup.maj1      = swap ? (steep ? i_y0 : i_x0) : (steep ? i_y1 : i_x1);
        o_setup.straight  = t_inc'(dmin) << 1;
        o_setup.diag      = (t_diag'(dmin) - t_diag'(dmaj)) <<< 1;
        o_setup.dec       = (t_dec'(dmin) <<< 1) - t_dec'(dmaj);
        o_setup.steep     = steep;
        o_setup.goes_down = swap ? ((dmin_s != '0) && !dmin_s[DIFF_W-1])
                                 : dmin_s[DIFF_W-1];
        o_setup.single    = (dmaj == '0);
    end

endmodule

@@ rtl/midpoint_line_rasterizer.sv @@
// channel   direction  handshake                 payload
// request   in         i_in_valid / o_in_ready   i_operation, i_start_x/y, i_end_x/y
// result    out        o_out_valid / i_out_ready o_pixel_x/y, o_pixel_valid,
//                                                o_on_screen, o_last_pixel
// config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// two register stages: the request register holds the prepared line set-up, the
// result register takes the pixel, so a request passes through both before it is offered.
// one request per cycle if results are taken; the single stepping register set is the loop.
// reset (synchronous, active low) drops any line and restores a 640 x 480 screen.
// a stalled result holds the pipe; the request register still drains into a free
// result register, so input ready only falls when both stages are full and the
// result is not being taken.
`include "assert_macros.svh"

module midpoint_line_rasterizer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_operation,
    input  mlr_pkg::t_coord          i_start_x,
    input  mlr_pkg::t_coord          i_start_y,
    input  mlr_pkg::t_coord          i_end_x,
    input  mlr_pkg::t_coord          i_end_y,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output mlr_pkg::t_coord          o_pixel_x,
    output mlr_pkg::t_coord          o_pixel_y,
    output logic                     o_pixel_valid,
    output logic                     o_on_screen,
    output logic                     o_last_pixel,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  mlr_pkg::t_screen         i_cfg_data
);
    import mlr_pkg::*;

    // screen size test for one pixel
    function automatic logic f_visible(t_coord x, t_coord y, t_screen w, t_screen h);
        logic x_in;
        logic y_in;
        x_in = !x[COORD_W-1] && (t_cmp'(x[COORD_W-2:0]) < t_cmp'(w));
        y_in = !y[COORD_W-1] && (t_cmp'(y[COORD_W-2:0]) < t_cmp'(h));
        return x_in && y_in;
    endfunction

    t_setup  setup;
    logic    in_acc;
    logic    s1_adv;

    // request stage
    logic    r_s1_valid;
    logic    r_s1_op;
    t_setup  r_s1_setup;

    // configuration
    t_screen r_width;
    t_screen r_height;

    // stepping state
    t_coord  r_major,     n_major;
    t_coord  r_minor,     n_minor;
    t_coord  r_major_end, n_major_end;
    t_dec    r_dec,       n_dec;
    t_inc    r_straight,  n_straight;
    t_diag   r_diag,      n_diag;
    logic    r_down,      n_down;
    logic    r_steep,     n_steep;
    logic    r_line_active, n_line_active;

    // result register
    logic    r_out_valid;
    t_coord  r_px_x,      n_px_x;
    t_coord  r_px_y,      n_px_y;
    logic    r_px_valid,  n_px_valid;
    logic    r_vis,       n_vis;
    logic    r_last,      n_last;

    // line set-up from the endpoints
    mlr_setup u_setup (
        .i_x0    (i_start_x),
        .i_y0    (i_start_y),
        .i_x1    (i_end_x),
        .i_y1    (i_end_y),
        .o_setup (setup)
    );

    // handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // start or step, then pixel formation
    always_comb begin
        n_major       = r_major;
        n_minor       = r_minor;
        n_major_end   = r_major_end;
        n_dec         = r_dec;
        n_straight    = r_straight;
        n_diag        = r_diag;
        n_down        = r_down;
        n_steep       = r_steep;
        n_line_active = r_line_active;
        n_px_valid    = 1'b0;
        n_last        = 1'b0;
        if (r_s1_op == OP_START) begin
            n_major       = r_s1_setup.maj0;
            n_minor       = r_s1_setup.min0;
            n_major_end   = r_s1_setup.maj1;
            n_dec         = r_s1_setup.dec;
            n_straight    = r_s1_setup.straight;
            n_diag        = r_s1_setup.diag;
            n_down        = r_s1_setup.goes_down;
            n_steep       = r_s1_setup.steep;
            n_line_active = !r_s1_setup.single;
            n_px_valid    = 1'b1;
            n_last        = r_s1_setup.single;
        end else if (r_line_active) begin
            if (r_dec <= t_dec'(0)) begin
                n_dec = r_dec + t_dec'(r_straight);
            end else begin
                n_dec   = r_dec + t_dec'(r_diag);
                n_minor = r_down ? r_minor - t_coord'(1) : r_minor + t_coord'(1);
            end
            n_major       = r_major + t_coord'(1);
            n_last        = n_major >= r_major_end;
            n_line_active = !n_last;
            n_px_valid    = 1'b1;
        end
        if (n_px_valid) begin
            n_px_x = n_steep ? n_minor : n_major;
            n_px_y = n_steep ? n_major : n_minor;
            n_vis  = f_visible(n_px_x, n_px_y, r_width, r_height);
        end else begin
            n_px_x = '0;
            n_px_y = '0;
            n_vis  = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_line_active <= 1'b0;
            r_width       <= t_screen'(640);
            r_height      <= t_screen'(480);
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid   <= 1'b1;
                r_line_active <= n_line_active;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default:           r_width  <= r_width;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_operation;
            r_s1_setup <= setup;
        end
        if (s1_adv) begin
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_major_end <= n_major_end;
            r_dec       <= n_dec;
            r_straight  <= n_straight;
            r_diag      <= n_diag;
            r_down      <= n_down;
            r_steep     <= n_steep;
            r_px_x      <= n_px_x;
            r_px_y      <= n_px_y;
            r_px_valid  <= n_px_valid;
            r_vis       <= n_vis;
            r_last      <= n_last;
        end
    end

    // outputs
    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px_x;
    assign o_pixel_y     = r_px_y;
    assign o_pixel_valid = r_px_valid;
    assign o_on_screen   = r_vis;
    assign o_last_pixel  = r_last;

    // checks
    `ASSERT_STD(a_last_ends_line, s1_adv && n_last |=> !r_line_active, "line active after last pixel")
    `ASSERT_STD(a_s1_held, r_s1_valid && !s1_adv |=> r_s1_valid, "pending request lost")
    `ASSERT_STD(a_major_below_end, r_line_active |-> r_major < r_major_end, "major past line end")
    `ASSERT_STD(a_diag_nonpos, r_line_active |-> r_diag <= t_diag'(0), "diagonal increment positive")

endmodule
